### hdl/smvs_pkg.sv
package smvs_pkg;

    // Sample word and result field widths
    localparam int SAMPLE_BITS = 24;
    localparam int W_SUM       = 30;
    localparam int W_MEAN      = 24;
    localparam int W_VAR       = 54;
    localparam int W_STD       = 27;
    localparam int W_CNT       = 7;

    // One incoming sample request
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic                          sample_last;
    } t_sample_in;

    // One result request, closing a data set
    typedef struct packed {
        logic signed [W_SUM-1:0]  sum_total;
        logic signed [W_MEAN-1:0] mean_value;
        logic [W_VAR-1:0]         variance_value;
        logic [W_STD-1:0]         std_deviation;
        logic [W_CNT-1:0]         sample_count;
        logic                     too_few;
        logic                     overflowed;
    } t_result;

endpackage

### hdl/smvs_ram.sv
module smvs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry into a register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/smvs_div.sv
module smvs_div #(
    parameter int NW = 55,
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [NW-1:0] o_quotient,
    output logic          o_done
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   r_q;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_dvs;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [DW:0]     w_trial;
    logic [DW:0]     w_diff;
    logic            w_fit;

    // Bring down the next dividend bit and try the divisor
    assign w_trial = {r_rem, r_q[NW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift quotient bits in as dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_quotient = r_q;
    assign o_done     = r_done;

endmodule

### hdl/smvs_sqacc.sv
module smvs_sqacc #(
    parameter int DW  = 24,
    parameter int ACW = 55
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  logic           i_start,
    input  logic [DW-1:0]  i_mag,
    output logic [ACW-1:0] o_acc,
    output logic           o_done
);

    localparam int CNTW = $clog2(DW + 1);

    logic [ACW-1:0]  r_acc;
    logic [ACW-1:0]  r_mcand;
    logic [DW-1:0]   r_mplier;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    // Sequence one square, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Add the shifted magnitude into the total where the multiplier bit is set
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_busy && r_mplier[0]) begin
            r_acc <= r_acc + r_mcand;
        end
        if (i_start) begin
            r_mcand  <= ACW'(i_mag);
            r_mplier <= i_mag;
        end else if (r_busy) begin
            r_mcand  <= {r_mcand[ACW-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[DW-1:1]};
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

### hdl/smvs_sqrt.sv
module smvs_sqrt #(
    parameter int VW = 55
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VW-1:0]          i_value,
    output logic [(VW+1)/2-1:0]    o_root,
    output logic                   o_done
);

    localparam int RW   = (VW + 1) / 2;
    localparam int PW   = 2 * RW;
    localparam int CNTW = $clog2(RW + 1);

    logic [PW-1:0]   r_val;
    logic [RW:0]     r_rem;
    logic [RW-1:0]   r_root;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [RW+2:0]   w_trial;
    logic [RW+2:0]   w_cand;
    logic [RW+2:0]   w_diff;
    logic            w_fit;

    // Bring down the next radix-4 digit and test root*4+1
    assign w_trial = {r_rem, r_val[PW-1 -: 2]};
    assign w_cand  = (RW + 3)'({r_root, 2'b01});
    assign w_fit   = (w_trial >= w_cand);
    assign w_diff  = w_trial - w_cand;

    // Sequence one root bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Advance the remainder and the partial root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= PW'(i_value);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[PW-3:0], 2'b00};
            r_rem  <= w_fit ? w_diff[RW:0] : w_trial[RW:0];
            r_root <= {r_root[RW-2:0], w_fit};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

### hdl/sample_mean_variance_stddev.sv
// Sample mean, variance and standard deviation over one data set.
// Input channel (i_in_valid / o_in_ready / i_in_data): one signed Q15.8 sample
// per request, sample_last marking the end of the data set. While loading,
// samples are taken at one per cycle; up to MAX_SAMPLES are stored, later
// ones are dropped and reported through the overflowed flag.
// Output channel (o_out_valid / i_out_ready / o_out_data): one result request
// per data set, holding total, mean, variance (Q.16), floor root (Q.8), count
// and the too_few / overflowed flags.
// After the last sample is taken, the result is worked out by the bit-serial
// divider (used twice when two or more samples are stored), the shift-add
// squaring unit (one pass per stored sample, read from the sample memory)
// and the radix-4 root unit.
// No sample is taken from the last one until the result has been accepted;
// a stalled receiver simply holds the result register and the block waits.
// Reset clears the count, total and overflow flag and returns to loading;
// the sample memory needs no clearing as only entries of the current set are
// read.
module sample_mean_variance_stddev #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  smvs_pkg::t_sample_in i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output smvs_pkg::t_result    o_out_data
);

    import smvs_pkg::*;

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int TW  = SAMPLE_BITS + CW;
    localparam int SQW = 2 * SAMPLE_BITS + CW;
    localparam int RW  = (SQW + 1) / 2;
    localparam int SXW = TW + W_SUM;
    localparam int VXW = SQW + W_VAR;
    localparam int DXW = RW + W_STD;
    localparam int CXW = CW + W_CNT;

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_MDIV = 7'b0000010,
        S_RD   = 7'b0000100,
        S_SQ   = 7'b0001000,
        S_VDIV = 7'b0010000,
        S_ROOT = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_go, n_go;
    logic [CW-1:0]                 r_count, n_count;
    logic signed [TW-1:0]          r_total, n_total;
    logic                          r_ovf, n_ovf;
    logic [AW-1:0]                 r_idx, n_idx;
    logic signed [SAMPLE_BITS-1:0] r_mean, n_mean;
    logic [SQW-1:0]                r_var, n_var;
    logic [RW-1:0]                 r_std, n_std;

    logic                          w_accept;
    logic                          w_room;
    logic [SAMPLE_BITS-1:0]        w_rdata;
    logic                          w_neg;
    logic [TW-1:0]                 w_abs;
    logic [SQW-1:0]                w_dividend;
    logic [CW-1:0]                 w_divisor;
    logic [SQW-1:0]                w_quo;
    logic                          w_div_done;
    logic [SAMPLE_BITS-1:0]        w_q_lo;
    logic [SAMPLE_BITS:0]          w_diff;
    logic [SAMPLE_BITS:0]          w_dabs;
    logic [SQW-1:0]                w_sq_acc;
    logic                          w_sq_done;
    logic [RW-1:0]                 w_root;
    logic                          w_root_done;
    logic                          w_last_idx;
    logic signed [SXW-1:0]         w_sum_ext;
    logic [VXW-1:0]                w_var_ext;
    logic [DXW-1:0]                w_std_ext;
    logic [CXW-1:0]                w_cnt_ext;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);
    assign w_accept    = i_in_valid & o_in_ready;
    assign w_room      = (r_count < CW'(MAX_SAMPLES));

    // Sample store
    smvs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept & w_room),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_data.sample_value),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Shared divider: magnitude of the total by count, then squares by count-1
    assign w_neg      = r_total[TW-1];
    assign w_abs      = w_neg ? TW'(-r_total) : TW'(r_total);
    assign w_dividend = (r_state == S_VDIV) ? w_sq_acc : SQW'(w_abs);
    assign w_divisor  = (r_state == S_VDIV) ? (r_count - CW'(1)) : r_count;

    smvs_div #(
        .NW (SQW),
        .DW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go && ((r_state == S_MDIV) || (r_state == S_VDIV))),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    assign w_q_lo = w_quo[SAMPLE_BITS-1:0];

    // Deviation magnitude of the sample just read from the store
    assign w_diff = {r_mean[SAMPLE_BITS-1], r_mean} - {w_rdata[SAMPLE_BITS-1], w_rdata};
    assign w_dabs = w_diff[SAMPLE_BITS] ? (~w_diff + (SAMPLE_BITS + 1)'(1)) : w_diff;

    smvs_sqacc #(
        .DW  (SAMPLE_BITS),
        .ACW (SQW)
    ) u_sqacc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (r_state == S_MDIV),
        .i_start (r_go && (r_state == S_SQ)),
        .i_mag   (w_dabs[SAMPLE_BITS-1:0]),
        .o_acc   (w_sq_acc),
        .o_done  (w_sq_done)
    );

    smvs_sqrt #(
        .VW (SQW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state == S_ROOT)),
        .i_value (r_var),
        .o_root  (w_root),
        .o_done  (w_root_done)
    );

    assign w_last_idx = (CW'(r_idx) == (r_count - CW'(1)));

    // Sequence loading, mean, squares, variance and root
    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        n_count = r_count;
        n_total = r_total;
        n_ovf   = r_ovf;
        n_idx   = r_idx;
        n_mean  = r_mean;
        n_var   = r_var;
        n_std   = r_std;
        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (w_room) begin
                        n_count = r_count + CW'(1);
                        n_total = r_total + TW'(i_in_data.sample_value);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.sample_last) begin
                        n_state = S_MDIV;
                        n_go    = 1'b1;
                    end
                end
            end
            S_MDIV: begin
                if (w_div_done) begin
                    n_mean  = w_neg ? (~w_q_lo + SAMPLE_BITS'(1)) : w_q_lo;
                    n_idx   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_SQ;
                n_go    = 1'b1;
            end
            S_SQ: begin
                if (w_sq_done) begin
                    if (w_last_idx) begin
                        if (r_count >= CW'(2)) begin
                            n_state = S_VDIV;
                            n_go    = 1'b1;
                        end else begin
                            n_var   = '0;
                            n_std   = '0;
                            n_state = S_OUT;
                        end
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_VDIV: begin
                if (w_div_done) begin
                    n_var   = w_quo;
                    n_state = S_ROOT;
                    n_go    = 1'b1;
                end
            end
            S_ROOT: begin
                if (w_root_done) begin
                    n_std   = w_root;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_count = '0;
                    n_total = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Hold control state and data-set totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_go    <= 1'b0;
            r_count <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_count <= n_count;
            r_total <= n_total;
            r_ovf   <= n_ovf;
        end
    end

    // Hold working and result values
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_mean <= n_mean;
        r_var  <= n_var;
        r_std  <= n_std;
    end

    // Fit internal widths to the result fields
    assign w_sum_ext = SXW'(r_total);
    assign w_var_ext = VXW'(r_var);
    assign w_std_ext = DXW'(r_std);
    assign w_cnt_ext = CXW'(r_count);

    always_comb begin
        o_out_data.sum_total      = w_sum_ext[W_SUM-1:0];
        o_out_data.mean_value     = r_mean;
        o_out_data.variance_value = w_var_ext[W_VAR-1:0];
        o_out_data.std_deviation  = w_std_ext[W_STD-1:0];
        o_out_data.sample_count   = w_cnt_ext[W_CNT-1:0];
        o_out_data.too_few        = (r_count == CW'(1));
        o_out_data.overflowed     = r_ovf;
    end

endmodule

### bench/smvs_result_check.sv
`timescale 1ns / 1ps

// Watches both channels of the statistics block, predicts each data set's
// result and compares it, field by field, with what the block sends out.
module smvs_result_check #(
    parameter int CAPACITY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  smvs_pkg::t_sample_in i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  smvs_pkg::t_result    i_out_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    import smvs_pkg::*;

    // Predicted state of the current data set
    logic signed [SAMPLE_BITS-1:0] held_samples [CAPACITY];
    int                            held_count;
    longint                        set_total;
    bit                            set_overflow;

    t_result expected_summaries [$];
    int      fail_count;

    // Print one line per fault and count every one
    task automatic report_fault(input string msg);
        $display("[%0t] result fault: %s", $time, msg);
        fail_count++;
    endtask

    // Bit-pair floor square root over 64 bits
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > v) begin
            probe >>= 2;
        end
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    -= root + probe;
                root  = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Close the current data set: total, mean, two-pass variance and root
    function automatic t_result summarise_data_set();
        t_result         summary;
        longint          mean;
        longint          dev;
        longint unsigned mag;
        longint unsigned sq_sum;
        longint unsigned variance;
        longint unsigned root;
        mean   = set_total / longint'(held_count);
        sq_sum = 0;
        for (int i = 0; i < held_count; i++) begin
            dev     = mean - longint'(held_samples[i]);
            mag     = (dev < 0) ? unsigned'(-dev) : unsigned'(dev);
            sq_sum += mag * mag;
        end
        variance = 0;
        root     = 0;
        if (held_count >= 2) begin
            variance = sq_sum / unsigned'(longint'(held_count - 1));
            root     = floor_root(variance);
        end
        summary.sum_total      = set_total[W_SUM-1:0];
        summary.mean_value     = mean[W_MEAN-1:0];
        summary.variance_value = variance[W_VAR-1:0];
        summary.std_deviation  = root[W_STD-1:0];
        summary.sample_count   = held_count[W_CNT-1:0];
        summary.too_few        = (held_count < 2);
        summary.overflowed     = set_overflow;
        return summary;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result wanted;
        if (!i_rst_n) begin
            held_count   = 0;
            set_total    = 0;
            set_overflow = 1'b0;
        end else begin
            // Store an accepted sample, or drop it once the store is full
            if (i_in_valid && i_in_ready) begin
                if (held_count < CAPACITY) begin
                    held_samples[held_count] = i_in_data.sample_value;
                    set_total  += longint'(i_in_data.sample_value);
                    held_count++;
                end else begin
                    set_overflow = 1'b1;
                end
                if (i_in_data.sample_last) begin
                    expected_summaries.push_back(summarise_data_set());
                    held_count   = 0;
                    set_total    = 0;
                    set_overflow = 1'b0;
                end
            end
            // Compare an accepted result with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_summaries.size() == 0) begin
                    report_fault("result request with no data set closed");
                end else begin
                    wanted = expected_summaries.pop_front();
                    if (i_out_data.sum_total !== wanted.sum_total)
                        report_fault($sformatf("sum_total got %0d want %0d",
                            i_out_data.sum_total, wanted.sum_total));
                    if (i_out_data.mean_value !== wanted.mean_value)
                        report_fault($sformatf("mean_value got %0d want %0d",
                            i_out_data.mean_value, wanted.mean_value));
                    if (i_out_data.variance_value !== wanted.variance_value)
                        report_fault($sformatf("variance_value got %0d want %0d",
                            i_out_data.variance_value, wanted.variance_value));
                    if (i_out_data.std_deviation !== wanted.std_deviation)
                        report_fault($sformatf("std_deviation got %0d want %0d",
                            i_out_data.std_deviation, wanted.std_deviation));
                    if (i_out_data.sample_count !== wanted.sample_count)
                        report_fault($sformatf("sample_count got %0d want %0d",
                            i_out_data.sample_count, wanted.sample_count));
                    if (i_out_data.too_few !== wanted.too_few)
                        report_fault($sformatf("too_few got %0b want %0b",
                            i_out_data.too_few, wanted.too_few));
                    if (i_out_data.overflowed !== wanted.overflowed)
                        report_fault($sformatf("overflowed got %0b want %0b",
                            i_out_data.overflowed, wanted.overflowed));
                end
            end
        end
        o_pending    <= expected_summaries.size();
        o_fail_count <= fail_count;
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import smvs_pkg::*;

    localparam int     STORE_DEPTH  = 64;
    localparam int     TOTAL_ITEMS  = 900;
    localparam int     LONG_HOLD    = 3000;
    localparam int     DRAIN_CYCLES = 2000;
    localparam longint RUN_LIMIT_NS = 64'd8_000_000;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_sample_in i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_result    o_out_data;

    int fail_count;
    int pending_results;

    // Stimulus bookkeeping
    logic signed [SAMPLE_BITS-1:0] set_values [$];
    int burst_left       = 0;
    int items_sent       = 0;
    int sets_sent        = 0;
    int single_sets      = 0;
    int overflow_sets    = 0;
    int drain_pauses     = 0;
    int hold_offs_asked  = 0;
    int hold_offs_done   = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    sample_mean_variance_stddev #(
        .MAX_SAMPLES(STORE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    smvs_result_check #(
        .CAPACITY(STORE_DEPTH)
    ) result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending_results)
    );

    // Offer one sample request in bursts, idling between most bursts
    task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
        t_sample_in request;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        request.sample_value = value;
        request.sample_last  = last;
        i_in_valid <= 1'b1;
        i_in_data  <= request;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Send the queued data set, marking its final sample as last
    task automatic play_data_set();
        int n;
        n = set_values.size();
        for (int i = 0; i < n; i++) begin
            offer_sample(set_values[i], i == n - 1);
        end
        sets_sent++;
        if (n == 1) single_sets++;
        if (n > STORE_DEPTH) overflow_sets++;
        set_values.delete();
    endtask

    // Hold the sender until every predicted result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        burst_left = 0;
        drain_pauses++;
    endtask

    // Draw one sample in the given style around an optional base
    function automatic logic signed [SAMPLE_BITS-1:0] pick_value(
        input int style, input logic signed [SAMPLE_BITS-1:0] base);
        logic [SAMPLE_BITS-1:0] raw;
        case (style)
            0: raw = SAMPLE_BITS'($urandom);
            1: raw = SAMPLE_BITS'($urandom_range(0, 1024)) - SAMPLE_BITS'(512);
            2: raw = base + SAMPLE_BITS'($urandom_range(0, 64)) - SAMPLE_BITS'(32);
            default: begin
                case ($urandom_range(0, 4))
                    0: raw = SAMPLE_MAX;
                    1: raw = SAMPLE_MIN;
                    2: raw = '0;
                    3: raw = SAMPLE_BITS'(1);
                    default: raw = '1;
                endcase
            end
        endcase
        return raw;
    endfunction

    // Receiver: segments of differing stall patterns, plus one long hold-off
    initial begin : receiver
        int seg_len;
        int mode;
        forever begin
            if (hold_offs_done < hold_offs_asked) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_offs_done++;
            end else begin
                seg_len = $urandom_range(10, 300);
                mode    = $urandom_range(0, 3);
                for (int k = 0; k < seg_len; k++) begin
                    case (mode)
                        0: i_out_ready <= 1'b1;
                        1: i_out_ready <= 1'($urandom_range(0, 1));
                        2: i_out_ready <= ($urandom_range(0, 7) == 0);
                        default: i_out_ready <= (k % 4 != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int len_pick;
        int style;
        int set_len;
        bit mid_pause_done;
        logic signed [SAMPLE_BITS-1:0] base;
        mid_pause_done = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single samples at both extremes
        set_values.push_back(SAMPLE_MAX);
        play_data_set();
        set_values.push_back(SAMPLE_MIN);
        play_data_set();
        // Widest spread between two samples
        set_values = '{SAMPLE_MAX, SAMPLE_MIN};
        play_data_set();
        // All equal: zero variance
        set_values = '{'0, '0, '0};
        play_data_set();
        // Negative total: mean truncates toward zero
        set_values = '{SAMPLE_BITS'(-3), SAMPLE_BITS'(-2)};
        play_data_set();
        set_values = '{SAMPLE_MIN, SAMPLE_MIN};
        play_data_set();
        set_values = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN};
        play_data_set();
        for (int i = 0; i < 5; i++) set_values.push_back(pick_value(0, '0));
        play_data_set();
        drain_results();

        // Long receiver hold-off while a full store and an overflowing set go in
        hold_offs_asked++;
        for (int i = 0; i < STORE_DEPTH; i++) set_values.push_back(SAMPLE_MAX);
        play_data_set();
        for (int i = 0; i < STORE_DEPTH + 2; i++) set_values.push_back(SAMPLE_MIN);
        play_data_set();

        // Random data sets of mixed sizes and value styles
        while (items_sent < TOTAL_ITEMS) begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 8)       set_len = 1;
            else if (len_pick < 65) set_len = $urandom_range(2, 8);
            else if (len_pick < 90) set_len = $urandom_range(9, 40);
            else                    set_len = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 8);
            style = $urandom_range(0, 3);
            base  = pick_value(0, '0);
            for (int i = 0; i < set_len; i++) set_values.push_back(pick_value(style, base));
            play_data_set();
            if (!mid_pause_done && items_sent >= TOTAL_ITEMS / 2) begin
                drain_results();
                mid_pause_done = 1'b1;
            end
        end

        // Wait for the last results, then allow for any stray output
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d samples in %0d data sets: %0d single-sample, %0d past capacity.",
                 items_sent, sets_sent, single_sets, overflow_sets);
        $display("Receiver held off for %0d cycles %0d time(s); sender drained %0d time(s).",
                 LONG_HOLD, hold_offs_done, drain_pauses);
        if (fail_count == 0 && pending_results == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Abandon a run that hangs
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("testbench failed");
        $finish;
    end

endmodule
